// ----- src/srbs_pkg.sv -----
// ----------------------------------------------------------------------------
// srbs_pkg
// Shared types and constants for the sorted range bounds search block.
// ----------------------------------------------------------------------------
package srbs_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int INDEX_WIDTH = 11;
   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [INDEX_WIDTH-1:0] NOT_FOUND = -11'sd1;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_LOAD_RESTART,
      CMD_QUERY
   } cmd_kind_type;

   // one classified command as it travels from front to back
   typedef struct packed {
      cmd_kind_type                  kind;
      logic signed [DATA_WIDTH-1:0]  value;
   } cmd_type;

endpackage

// ----- src/srbs_front.sv -----
// ----------------------------------------------------------------------------
// srbs_front
// Takes request transfers, classifies them and holds them for the queue.
// ----------------------------------------------------------------------------
module srbs_front
   import srbs_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic                          req_restart,
   input  logic signed [DATA_WIDTH-1:0]  req_element,
   input  logic signed [DATA_WIDTH-1:0]  req_target,
   input  logic                          queue_full,
   output logic                          push,
   output cmd_type                       push_cmd
);

   logic    slot_valid_ff, slot_valid_in;
   cmd_type slot_cmd_ff, slot_cmd_in;
   cmd_type classified;
   logic    accept;

   always_comb begin
      if (req_op) begin
         classified.kind  = CMD_QUERY;
         classified.value = req_target;
      end else begin
         classified.kind  = req_restart ? CMD_LOAD_RESTART : CMD_LOAD;
         classified.value = req_element;
      end
   end

   assign busy     = slot_valid_ff & queue_full;
   assign accept   = start & ~busy;
   assign push     = slot_valid_ff & ~queue_full;
   assign push_cmd = slot_cmd_ff;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_cmd_in   = slot_cmd_ff;
      if (accept) begin
         slot_valid_in = 1'b1;
         slot_cmd_in   = classified;
      end else if (push) begin
         slot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      slot_cmd_ff <= slot_cmd_in;
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

endmodule

// ----- src/srbs_queue.sv -----
// ----------------------------------------------------------------------------
// srbs_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module srbs_queue
   import srbs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   output logic     not_empty,
   input  logic     pop,
   output cmd_type  head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entries_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/srbs_back.sv -----
// ----------------------------------------------------------------------------
// srbs_back
// Executes loads into the element memory and runs both bound searches.
// ----------------------------------------------------------------------------
module srbs_back
   import srbs_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024
)(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_ready,
   input  cmd_type                        cmd,
   output logic                           pop,
   output logic                           rsp_strobe,
   output logic signed [INDEX_WIDTH-1:0]  rsp_first_index,
   output logic signed [INDEX_WIDTH-1:0]  rsp_last_index,
   output logic                           rsp_overflowed
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LB_READ,
      ST_LB_CMP,
      ST_LB_FIN,
      ST_UB_READ,
      ST_UB_CMP,
      ST_UB_FIN
   } state_type;

   state_type state_ff, state_in;

   logic signed [DATA_WIDTH-1:0] mem [MAX_ELEMENTS];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]                rd_addr;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hip_ff, hip_in;      // exclusive upper bound, hi + 1
   logic [CW-1:0] mid_ff, mid_in;
   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic signed [INDEX_WIDTH-1:0] first_ff, first_in;

   logic          rsp_strobe_ff, rsp_strobe_in;
   logic signed [INDEX_WIDTH-1:0] rsp_first_ff, rsp_first_in;
   logic signed [INDEX_WIDTH-1:0] rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic [CW-1:0] span, mid, hm1, base;
   logic          key_hit;

   assign span    = hip_ff - lo_ff - 1'b1;
   assign mid     = lo_ff + (span >> 1);
   assign hm1     = hip_ff - 1'b1;
   assign key_hit = (rd_data_ff == key_ff);
   assign base    = (cmd.kind == CMD_LOAD_RESTART) ? '0 : count_ff;
   assign wr_addr = base[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      lo_in         = lo_ff;
      hip_in        = hip_ff;
      mid_in        = mid_ff;
      key_in        = key_ff;
      first_in      = first_ff;
      rsp_strobe_in = 1'b0;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      rd_addr       = mid[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_ready) begin
               pop = 1'b1;
               unique case (cmd.kind) inside
                  CMD_LOAD, CMD_LOAD_RESTART: begin
                     if (cmd.kind == CMD_LOAD_RESTART) begin
                        ovf_in = 1'b0;
                     end
                     if (base < CW'(MAX_ELEMENTS)) begin
                        wr_en    = 1'b1;
                        count_in = base + 1'b1;
                     end else begin
                        ovf_in   = 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     key_in   = cmd.value;
                     lo_in    = '0;
                     hip_in   = count_ff;
                     state_in = ST_LB_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_LB_READ: begin
            if (lo_ff < hip_ff) begin
               mid_in   = mid;
               state_in = ST_LB_CMP;
            end else begin
               rd_addr  = lo_ff[AW-1:0];
               state_in = ST_LB_FIN;
            end
         end
         ST_LB_CMP: begin
            if (rd_data_ff < key_ff) begin
               lo_in  = mid_ff + 1'b1;
            end else begin
               hip_in = mid_ff;
            end
            state_in = ST_LB_READ;
         end
         ST_LB_FIN: begin
            first_in = (lo_ff < count_ff && key_hit) ?
                       $signed(INDEX_WIDTH'(lo_ff)) : NOT_FOUND;
            lo_in    = '0;
            hip_in   = count_ff;
            state_in = ST_UB_READ;
         end
         ST_UB_READ: begin
            if (lo_ff < hip_ff) begin
               mid_in   = mid;
               state_in = ST_UB_CMP;
            end else begin
               rd_addr  = hm1[AW-1:0];
               state_in = ST_UB_FIN;
            end
         end
         ST_UB_CMP: begin
            if (rd_data_ff <= key_ff) begin
               lo_in  = mid_ff + 1'b1;
            end else begin
               hip_in = mid_ff;
            end
            state_in = ST_UB_READ;
         end
         ST_UB_FIN: begin
            rsp_strobe_in = 1'b1;
            rsp_first_in  = first_ff;
            rsp_last_in   = (hip_ff != '0 && key_hit) ?
                            $signed(INDEX_WIDTH'(hm1)) : NOT_FOUND;
            rsp_ovf_in    = ovf_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // element memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hip_ff       <= hip_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      first_ff     <= first_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_first_index = rsp_first_ff;
   assign rsp_last_index  = rsp_last_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

endmodule

// ----- src/sorted_range_bounds_search.sv -----
// ----------------------------------------------------------------------------
// sorted_range_bounds_search
// First and last occurrence search over a loaded non-decreasing array.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load (req_op = 0)
// appends req_element to the array; req_restart empties the array and clears
// the overflow flag first. Loads beyond MAX_ELEMENTS are dropped and set the
// sticky overflow flag. A query (req_op = 1) answers with the first and last
// index holding req_target, or -1 for both, plus the overflow flag. Results
// appear for exactly one cycle with rsp_strobe high; the receiver cannot stall
// them, so capture on every strobe. Loads produce no result. A load is
// written from the idle state without leaving it. A query runs the lower
// bound search, then the upper bound search; each binary-search probe is
// a memory read, then a compare, about ceil(log2(n+1)) probes per search
// for n loaded elements, plus a final read and check of each. Probes run
// one after another, since the element memory has a single read port. A
// two-entry queue and a front holding slot absorb requests while a search
// runs; busy rises only when both are full. The element memory needs no
// clearing: only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module sorted_range_bounds_search
   import srbs_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024
)(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_op,
   input  logic                           req_restart,
   input  logic signed [DATA_WIDTH-1:0]   req_element,
   input  logic signed [DATA_WIDTH-1:0]   req_target,
   output logic                           rsp_strobe,
   output logic signed [INDEX_WIDTH-1:0]  rsp_first_index,
   output logic signed [INDEX_WIDTH-1:0]  rsp_last_index,
   output logic                           rsp_overflowed
);

   logic    push, pop, queue_full, queue_not_empty;
   cmd_type push_cmd, head_cmd;

   // front: request transfer and classification
   srbs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_restart (req_restart),
      .req_element (req_element),
      .req_target  (req_target),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decoupling queue, keeps command order
   srbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (pop),
      .head      (head_cmd)
   );

   // back: element store and the two bound searches
   srbs_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_ready       (queue_not_empty),
      .cmd             (head_cmd),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_first_index (rsp_first_index),
      .rsp_last_index  (rsp_last_index),
      .rsp_overflowed  (rsp_overflowed)
   );

endmodule

// ----- tb/sorted_range_bounds_search_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_bounds_search_checker
// Watches both channels, keeps a shadow array and scores every result.
// ----------------------------------------------------------------------------
module sorted_range_bounds_search_checker
   import srbs_pkg::*;
#(
   parameter int MAX_ELEMENTS = 1024
)(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_op,
   input  logic                           req_restart,
   input  logic signed [DATA_WIDTH-1:0]   req_element,
   input  logic signed [DATA_WIDTH-1:0]   req_target,
   input  logic                           rsp_strobe,
   input  logic signed [INDEX_WIDTH-1:0]  rsp_first_index,
   input  logic signed [INDEX_WIDTH-1:0]  rsp_last_index,
   input  logic                           rsp_overflowed,
   output int                             fail_count,
   output int                             pending_count,
   output int                             load_count,
   output int                             query_count,
   output int                             hit_count,
   output int                             overflow_count
);

   typedef struct {
      logic signed [INDEX_WIDTH-1:0] first_index;
      logic signed [INDEX_WIDTH-1:0] last_index;
      logic                          overflowed;
   } bounds_result_type;

   logic signed [DATA_WIDTH-1:0] shadow_elements [MAX_ELEMENTS];
   int                           shadow_fill;
   logic                         shadow_overflow;
   bounds_result_type            bounds_expected [$];

   int failures  = 0;
   int loads     = 0;
   int queries   = 0;
   int hits      = 0;
   int overflows = 0;

   assign fail_count     = failures;
   assign load_count     = loads;
   assign query_count    = queries;
   assign hit_count      = hits;
   assign overflow_count = overflows;

   initial pending_count = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      failures++;
   endtask

   // lower bound, then upper bound, each kept only if the probed entry matches
   function automatic bounds_result_type search_bounds(
         input logic signed [DATA_WIDTH-1:0] key);
      bounds_result_type r;
      int lo;
      int hi;
      int mid;
      r.first_index = NOT_FOUND;
      r.last_index  = NOT_FOUND;
      r.overflowed  = shadow_overflow;
      if (shadow_fill > 0) begin
         lo = 0;
         hi = shadow_fill - 1;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_elements[mid] < key) lo = mid + 1;
            else hi = mid - 1;
         end
         if (lo < shadow_fill && shadow_elements[lo] == key)
            r.first_index = lo[INDEX_WIDTH-1:0];
         lo = 0;
         hi = shadow_fill - 1;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_elements[mid] <= key) lo = mid + 1;
            else hi = mid - 1;
         end
         if (hi >= 0 && hi < shadow_fill && shadow_elements[hi] == key)
            r.last_index = hi[INDEX_WIDTH-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      bounds_result_type want;
      if (reset) begin
         shadow_fill     = 0;
         shadow_overflow = 1'b0;
         bounds_expected.delete();
      end else begin
         // result side first: a query taken at this edge cannot answer at it
         if (rsp_strobe) begin
            if (bounds_expected.size() == 0) begin
               report_mismatch("result with no query outstanding");
            end else begin
               want = bounds_expected.pop_front();
               if (rsp_first_index !== want.first_index)
                  report_mismatch($sformatf("first_index expected %0d, got %0d",
                                            want.first_index, rsp_first_index));
               if (rsp_last_index !== want.last_index)
                  report_mismatch($sformatf("last_index expected %0d, got %0d",
                                            want.last_index, rsp_last_index));
               if (rsp_overflowed !== want.overflowed)
                  report_mismatch($sformatf("overflowed expected %0b, got %0b",
                                            want.overflowed, rsp_overflowed));
               if (want.first_index != NOT_FOUND) hits++;
               if (want.overflowed) overflows++;
            end
         end
         if (start && !busy) begin
            if (req_op == 1'b0) begin
               loads++;
               if (req_restart) begin
                  shadow_fill     = 0;
                  shadow_overflow = 1'b0;
               end
               if (shadow_fill < MAX_ELEMENTS) begin
                  shadow_elements[shadow_fill] = req_element;
                  shadow_fill++;
               end else begin
                  shadow_overflow = 1'b1;
               end
            end else begin
               queries++;
               bounds_expected.insert(bounds_expected.size(), search_bounds(req_target));
            end
         end
      end
      pending_count <= bounds_expected.size();
   end

endmodule

// ----- tb/sorted_range_bounds_search_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_bounds_search_test
// Stimulus and verdict for the first/last occurrence search block.
// ----------------------------------------------------------------------------
// A directed burst covers the empty array, duplicates at both ends of the
// signed range, index zero, restart on a query and an unsorted array. One
// full fill then drives the array past its depth. The bulk is sorted arrays
// of random size and spread, each queried for present, neighbouring, extreme
// and random targets, with unsorted loads mixed in as noise. Pacing of the
// sender changes by phase; the checker beside the block does all scoring.
// ----------------------------------------------------------------------------
module sorted_range_bounds_search_test
   import srbs_pkg::*;
();

   localparam int MAX_ELEMENTS   = 1024;
   localparam int RANDOM_ITEMS   = 750;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 100;
   localparam int INT_MIN        = 32'sh8000_0000;
   localparam int INT_MAX        = 32'sh7fff_ffff;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_op;
   logic                          req_restart;
   logic signed [DATA_WIDTH-1:0]  req_element;
   logic signed [DATA_WIDTH-1:0]  req_target;
   logic                          rsp_strobe;
   logic signed [INDEX_WIDTH-1:0] rsp_first_index;
   logic signed [INDEX_WIDTH-1:0] rsp_last_index;
   logic                          rsp_overflowed;

   int fail_count;
   int pending_count;
   int load_count;
   int query_count;
   int hit_count;
   int overflow_count;

   int idle_pct     = 0;   // percent chance that the sender holds off before an item, and again while off
   int random_items = 0;
   int stall_cycles = 0;

   sorted_range_bounds_search #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_restart     (req_restart),
      .req_element     (req_element),
      .req_target      (req_target),
      .rsp_strobe      (rsp_strobe),
      .rsp_first_index (rsp_first_index),
      .rsp_last_index  (rsp_last_index),
      .rsp_overflowed  (rsp_overflowed)
   );

   sorted_range_bounds_search_checker #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_restart     (req_restart),
      .req_element     (req_element),
      .req_target      (req_target),
      .rsp_strobe      (rsp_strobe),
      .rsp_first_index (rsp_first_index),
      .rsp_last_index  (rsp_last_index),
      .rsp_overflowed  (rsp_overflowed),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .load_count      (load_count),
      .query_count     (query_count),
      .hit_count       (hit_count),
      .overflow_count  (overflow_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", stall_cycles);
            $display("sorted_range_bounds_search test failed");
            $finish;
         end
      end
   end

   // One request transfer. start is only lowered when a gap is taken, so a
   // back-to-back item never sees start fall and rise in the same step.
   task automatic send_item(input logic op, input logic restart,
                            input int element, input int target);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      start       <= 1'b1;
      req_op      <= op;
      req_restart <= restart;
      req_element <= element;
      req_target  <= target;
      do @(posedge clock); while (busy);
   endtask

   // Hold the sender off until every outstanding query has answered. The
   // first edge lets the checker's count take in the last transfer.
   task automatic wait_results_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // One sorted array: restart load, more loads climbing by random steps,
   // optional unsorted tail as noise, then a handful of queries.
   task automatic run_sorted_array();
      int     vals [$];
      int     n;
      int     nq;
      int     r;
      int     span;
      int     tgt;
      longint level;
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 12);
      else if (r < 95) n = $urandom_range(13, 80);
      else n = $urandom_range(81, 300);
      case ($urandom_range(0, 3))
         0:       span = 1;
         1:       span = 16;
         2:       span = 1 << 20;
         default: span = 1 << 28;
      endcase
      if ($urandom_range(0, 9) == 0) level = INT_MIN;
      else level = longint'(int'($urandom));
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 9) >= 3) level = level + $urandom_range(1, span);
         if (level > INT_MAX) level = INT_MAX;
         vals.insert(vals.size(), int'(level));
         send_item(1'b0, i == 0, int'(level), $urandom);
         random_items++;
      end
      // noise: a value that most likely breaks the ordering
      if ($urandom_range(0, 9) == 0) begin
         tgt = $urandom;
         vals.insert(vals.size(), tgt);
         send_item(1'b0, 1'b0, tgt, $urandom);
         random_items++;
      end
      if ($urandom_range(0, 19) == 0) wait_results_drained();
      nq = $urandom_range(1, 6);
      for (int q = 0; q < nq; q++) begin
         r = $urandom_range(0, 99);
         if (r < 50) tgt = vals[$urandom_range(0, vals.size() - 1)];
         else if (r < 65) tgt = vals[$urandom_range(0, vals.size() - 1)] + (r[0] ? 1 : -1);
         else if (r < 75) tgt = r[0] ? INT_MAX : INT_MIN;
         else tgt = $urandom;
         // restart on a query is ignored, so it is left random
         send_item(1'b1, $urandom_range(0, 1), $urandom, tgt);
         random_items++;
      end
   endtask

   initial begin
      int     fill_vals [$];
      longint lvl;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_op      <= 1'b0;
      req_restart <= 1'b0;
      req_element <= '0;
      req_target  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // empty array, with and without the restart bit on the query
      send_item(1'b1, 1'b0, 0, 0);
      send_item(1'b1, 1'b1, INT_MAX, INT_MIN);
      // duplicates at both ends of the signed range and in the middle
      send_item(1'b0, 1'b1, INT_MIN, INT_MAX);
      send_item(1'b0, 1'b0, INT_MIN, 0);
      send_item(1'b0, 1'b0, -5, 0);
      send_item(1'b0, 1'b0, 0, 0);
      send_item(1'b0, 1'b0, 0, 0);
      send_item(1'b0, 1'b0, 0, 0);
      send_item(1'b0, 1'b0, INT_MAX, 0);
      send_item(1'b0, 1'b0, INT_MAX, 0);
      send_item(1'b1, 1'b0, -1, INT_MIN);   // match at index zero
      send_item(1'b1, 1'b0, 0, 0);
      send_item(1'b1, 1'b0, 0, INT_MAX);
      send_item(1'b1, 1'b0, 0, -6);         // absent, between entries
      send_item(1'b1, 1'b0, 0, 1);
      send_item(1'b1, 1'b1, INT_MAX, -5);   // restart on query leaves array alone
      // single entry, then an unsorted pair
      send_item(1'b0, 1'b1, 7, -1);
      send_item(1'b1, 1'b0, 0, 7);
      send_item(1'b1, 1'b0, 0, 8);
      send_item(1'b1, 1'b0, 0, 6);
      send_item(1'b0, 1'b0, 3, 0);
      send_item(1'b1, 1'b0, 0, 3);
      send_item(1'b1, 1'b0, 0, 7);
      wait_results_drained();

      // ---- full array, overflow, then restart clears the flag ----
      idle_pct = 26;
      lvl = INT_MIN + $urandom_range(0, 1000);
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         if (i > 0 && $urandom_range(0, 3) != 0) lvl = lvl + $urandom_range(1, 1 << 22);
         if (lvl > INT_MAX) lvl = INT_MAX;
         fill_vals.insert(fill_vals.size(), int'(lvl));
         send_item(1'b0, i == 0, int'(lvl), $urandom);
      end
      send_item(1'b1, 1'b0, 0, fill_vals[0]);
      send_item(1'b1, 1'b0, 0, fill_vals[MAX_ELEMENTS-1]);
      for (int q = 0; q < 8; q++)
         send_item(1'b1, 1'b0, 0, fill_vals[$urandom_range(0, MAX_ELEMENTS-1)]);
      repeat (3) send_item(1'b0, 1'b0, $urandom, $urandom);   // dropped
      send_item(1'b1, 1'b0, 0, fill_vals[$urandom_range(0, MAX_ELEMENTS-1)]);
      send_item(1'b1, 1'b1, 0, $urandom);
      send_item(1'b0, 1'b1, 42, 0);
      send_item(1'b1, 1'b0, 0, 42);
      wait_results_drained();

      // ---- random, in pacing phases ----
      while (random_items < RANDOM_ITEMS) begin
         if (random_items < RANDOM_ITEMS / 4) idle_pct = 0;
         else if (random_items < RANDOM_ITEMS / 2) idle_pct = 76;
         else if (random_items < 3 * RANDOM_ITEMS / 4) idle_pct = 26;
         else begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 26;
               2:       idle_pct = 76;
               default: idle_pct = 95;
            endcase
         end
         run_sorted_array();
         if ($urandom_range(0, 15) == 0) wait_results_drained();
      end

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d loads and %0d queries; %0d answers found the target,",
               load_count, query_count, hit_count);
      $display("%0d answers carried the overflow flag, over four sender pacings",
               overflow_count);
      if (fail_count == 0) begin
         $display("sorted_range_bounds_search test passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("sorted_range_bounds_search test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/srbs_pkg.sv
src/srbs_front.sv
src/srbs_queue.sv
src/srbs_back.sv
src/sorted_range_bounds_search.sv
tb/sorted_range_bounds_search_checker.sv
tb/sorted_range_bounds_search_test.sv
